// ===== design/i2cws_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C write sequencer package
// Phase and command codes plus the sequencer state and result types.
// ----------------------------------------------------------------------------
package i2cws_pkg;

  localparam int unsigned PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_IDLE     = 4'd0;
  localparam logic [PhaseW-1:0] PH_START_A  = 4'd1;
  localparam logic [PhaseW-1:0] PH_START_B  = 4'd2;
  localparam logic [PhaseW-1:0] PH_START_C  = 4'd3;
  localparam logic [PhaseW-1:0] PH_BIT_LOW  = 4'd4;
  localparam logic [PhaseW-1:0] PH_BIT_HIGH = 4'd5;
  localparam logic [PhaseW-1:0] PH_ACK_REL  = 4'd6;
  localparam logic [PhaseW-1:0] PH_ACK_HIGH = 4'd7;
  localparam logic [PhaseW-1:0] PH_ACK_LOW  = 4'd8;
  localparam logic [PhaseW-1:0] PH_STOP_A   = 4'd9;
  localparam logic [PhaseW-1:0] PH_STOP_B   = 4'd10;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_BYTE  = 3'd3;
  localparam logic [2:0] OP_ADDR  = 3'd4;
  localparam logic [2:0] OP_PROBE = 3'd5;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [2:0]        bit_cnt;
    logic [7:0]        shift;
    logic [15:0]       hold;
    logic              scl;
    logic              sda;
    logic              ack_failed;
    logic [2:0]        cmd;
  } seq_state_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic done_res;
    logic nack_error;
  } seq_result_t;

endpackage

// ===== design/i2cws_next.sv =====
// ----------------------------------------------------------------------------
// I2C write sequencer next-state logic
// Computes the sequencer state and the result for one accepted transaction.
// ----------------------------------------------------------------------------
module i2cws_next (
  input  i2cws_pkg::seq_state_t  cur,
  input  logic [15:0]            half_period,
  input  logic [2:0]             operation,
  input  logic [7:0]             data_byte,
  input  logic [6:0]             slave_address,
  input  logic                   read_direction,
  input  logic                   sda_sample,
  output i2cws_pkg::seq_state_t  nxt,
  output i2cws_pkg::seq_result_t res
);
  import i2cws_pkg::*;

  logic [15:0] reload;
  logic [15:0] hold_dec;
  logic        finish;
  logic [7:0]  shifted;

  assign reload   = (half_period == 16'd0) ? 16'd1 : half_period;
  assign hold_dec = cur.hold - 16'd1;
  assign shifted  = {cur.shift[6:0], 1'b0};

  always_comb begin
    nxt    = cur;
    finish = 1'b0;
    if (cur.phase == PH_IDLE) begin
      if (operation >= OP_START && operation <= OP_PROBE) begin
        nxt.cmd        = operation;
        nxt.ack_failed = 1'b0;
        nxt.hold       = reload;
        unique case (operation)
          OP_STOP: begin
            nxt.phase = PH_STOP_A;
            nxt.scl   = 1'b1;
            nxt.sda   = 1'b0;
          end
          OP_BYTE: begin
            nxt.shift   = data_byte;
            nxt.bit_cnt = 3'd0;
            nxt.phase   = PH_BIT_LOW;
            nxt.scl     = 1'b0;
            nxt.sda     = data_byte[7];
          end
          OP_ADDR: begin
            nxt.shift   = {slave_address, read_direction};
            nxt.bit_cnt = 3'd0;
            nxt.phase   = PH_BIT_LOW;
            nxt.scl     = 1'b0;
            nxt.sda     = slave_address[6];
          end
          OP_PROBE: begin
            nxt.shift = {slave_address, 1'b0};
            nxt.phase = PH_START_A;
            nxt.scl   = 1'b1;
            nxt.sda   = 1'b1;
          end
          default: begin
            nxt.phase = PH_START_A;
            nxt.scl   = 1'b1;
            nxt.sda   = 1'b1;
          end
        endcase
      end
    end else if (operation == OP_TICK) begin
      nxt.hold = hold_dec;
      if (hold_dec == 16'd0) begin
        // Every transition other than finishing reloads the level timer.
        nxt.hold = reload;
        unique case (cur.phase)
          PH_START_A: begin
            nxt.phase = PH_START_B;
            nxt.scl   = 1'b1;
            nxt.sda   = 1'b0;
          end
          PH_START_B: begin
            nxt.phase = PH_START_C;
            nxt.scl   = 1'b0;
            nxt.sda   = 1'b0;
          end
          PH_START_C: begin
            if (cur.cmd == OP_PROBE) begin
              nxt.bit_cnt = 3'd0;
              nxt.phase   = PH_BIT_LOW;
              nxt.scl     = 1'b0;
              nxt.sda     = cur.shift[7];
            end else begin
              finish = 1'b1;
            end
          end
          PH_BIT_LOW: begin
            nxt.phase = PH_BIT_HIGH;
            nxt.scl   = 1'b1;
          end
          PH_BIT_HIGH: begin
            if (cur.bit_cnt == LAST_BIT) begin
              nxt.phase = PH_ACK_REL;
              nxt.scl   = 1'b0;
              nxt.sda   = 1'b1;
            end else begin
              nxt.bit_cnt = cur.bit_cnt + 3'd1;
              nxt.shift   = shifted;
              nxt.phase   = PH_BIT_LOW;
              nxt.scl     = 1'b0;
              nxt.sda     = shifted[7];
            end
          end
          PH_ACK_REL: begin
            nxt.phase = PH_ACK_HIGH;
            nxt.scl   = 1'b1;
            nxt.sda   = 1'b1;
          end
          PH_ACK_HIGH: begin
            nxt.ack_failed = sda_sample;
            nxt.phase      = PH_ACK_LOW;
            nxt.scl        = 1'b0;
            nxt.sda        = 1'b1;
          end
          PH_ACK_LOW: begin
            // A NACK or a probe closes the bus with a stop condition.
            if (cur.ack_failed || cur.cmd == OP_PROBE) begin
              nxt.phase = PH_STOP_A;
              nxt.scl   = 1'b1;
              nxt.sda   = 1'b0;
            end else begin
              finish = 1'b1;
            end
          end
          PH_STOP_A: begin
            nxt.phase = PH_STOP_B;
            nxt.scl   = 1'b1;
            nxt.sda   = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (finish) begin
          nxt.phase = PH_IDLE;
          nxt.hold  = 16'd0;
        end
      end
    end
  end

  assign res.scl_level  = nxt.scl;
  assign res.sda_level  = nxt.sda;
  assign res.busy_res   = (nxt.phase != PH_IDLE);
  assign res.done_res   = finish;
  assign res.nack_error = finish & cur.ack_failed;

endmodule

// ===== design/i2c_master_write_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// I2C master write sequencer
// Write-only I2C master that produces open-drain SCL and SDA levels.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries either a command (start, stop, send
// byte, send address, probe) or a tick. A command is taken only while the
// sequencer is idle; later commands are ignored until it finishes. Ticks pace
// the bus: every SCL/SDA level is held for cfg half period ticks. Every input
// transaction yields exactly one output transaction with the driven levels,
// busy, and on the finishing tick done plus the NACK flag.
// The result is registered and offered in the cycle after acceptance.
// One transaction per cycle while in_stall is low; the next-state logic
// is a single combinational pass between the state and result registers.
// When out_stall holds a result, in_stall rises so that no result is lost;
// it falls as soon as that result is taken.
// Reset (synchronous, rst_n low) sets the half period to one tick, returns
// the sequencer to idle with both lines released and clears the result
// valid flag. cfg_wr_en writes the half period, used at the next transition.
// ----------------------------------------------------------------------------
module i2c_master_write_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic [6:0]  in_slave_address,
  input  logic        in_read_direction,
  input  logic        in_sda_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_level,
  output logic        out_sda_level,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_nack_error
);
  import i2cws_pkg::*;

  seq_state_t  state_r;
  seq_state_t  state_nxt;
  seq_result_t res_nxt;
  seq_result_t res_r;
  logic [15:0] half_period_r;
  logic        out_valid_r;
  logic        accept;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  i2cws_next u_next (
    .cur            (state_r),
    .half_period    (half_period_r),
    .operation      (in_operation),
    .data_byte      (in_data_byte),
    .slave_address  (in_slave_address),
    .read_direction (in_read_direction),
    .sda_sample     (in_sda_sample),
    .nxt            (state_nxt),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= 16'd1;
    end else if (cfg_wr_en) begin
      half_period_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= PH_IDLE;
      state_r.bit_cnt    <= 3'd0;
      state_r.shift      <= 8'd0;
      state_r.hold       <= 16'd0;
      state_r.scl        <= 1'b1;
      state_r.sda        <= 1'b1;
      state_r.ack_failed <= 1'b0;
      state_r.cmd        <= OP_TICK;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_level  = res_r.scl_level;
  assign out_sda_level  = res_r.sda_level;
  assign out_busy_res   = res_r.busy_res;
  assign out_done_res   = res_r.done_res;
  assign out_nack_error = res_r.nack_error;

`ifndef SYNTHESIS
  // A running sequence always has a level timer left to count down.
  a_hold_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase != PH_IDLE) |-> (state_r.hold != 16'd0))
    else $error("busy sequencer with empty level timer");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_res) |-> !out_busy_res)
    else $error("done reported while still busy");

  a_nack_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_nack_error) |-> out_done_res)
    else $error("NACK reported without done");

  a_state_holds_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(state_r))
    else $error("sequencer state moved while input stalled");
`endif

endmodule
